FILE: rtl/assert_macros.svh
// assertion helpers, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/gsmr_pkg.sv
package gsmr_pkg;

    localparam int TABLE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int IDX_W       = ADDR_W + 1;
    localparam int CNT_W       = 17;
    localparam int TIME_W      = 48;
    localparam int COORD_W     = 30;
    localparam int ENTRY_W     = TIME_W + 3 * COORD_W;
    localparam int DIST_W      = 62;
    localparam int ROOT_W      = 31;
    localparam int Q_FRAC      = 24;
    localparam int STEP_W      = 7;
    localparam int SPAN_TOL    = 2;
    localparam int STEP_LIMIT  = 96;

    localparam logic [Q_FRAC-1:0] GOLD_Q = 24'd10368890;
    localparam logic [Q_FRAC-1:0] COMP_Q = 24'd6408897;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MID_MUL, ST_MID_SET, ST_PRB_MUL, ST_PRB_SET,
        ST_MIX_FAR, ST_MIX_NEAR, ST_MIX_SET,
        ST_D_ADDR, ST_D_X, ST_D_Y, ST_D_Z, ST_D_SUM,
        ST_LOOP, ST_F_ADDR, ST_F_READ, ST_ROOT, ST_OUT
    } state_t;

    function automatic logic [ADDR_W-1:0] clamp_addr(input logic [IDX_W-1:0] p,
                                                     input logic [ADDR_W-1:0] last);
        if (p > IDX_W'(last)) begin
            return last;
        end
        return p[ADDR_W-1:0];
    endfunction

endpackage

FILE: rtl/gsmr_ram.sv
module gsmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/gsmr_isqrt.sv
`include "assert_macros.svh"

// digit-by-digit floor square root, two radicand bits per cycle
module gsmr_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [gsmr_pkg::DIST_W-1:0] value,
    output logic                        done,
    output logic [gsmr_pkg::ROOT_W-1:0] root
);

    localparam int REM_W = gsmr_pkg::ROOT_W + 3;

    logic [gsmr_pkg::DIST_W-1:0] val_reg, val_next;
    logic [gsmr_pkg::DIST_W-1:0] orig_reg, orig_next;
    logic [REM_W-1:0]            rem_reg, rem_next;
    logic [gsmr_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [4:0]                  cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [REM_W-1:0]            rem_sh;
    logic [REM_W-1:0]            trial;

    always_comb begin
        rem_sh    = {rem_reg[REM_W-3:0], val_reg[gsmr_pkg::DIST_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        val_next  = val_reg;
        orig_next = orig_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            val_next  = value;
            orig_next = value;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 5'(gsmr_pkg::ROOT_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            val_next = {val_reg[gsmr_pkg::DIST_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[gsmr_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[gsmr_pkg::ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        val_reg  <= val_next;
        orig_reg <= orig_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

    `ASSERT_IMP(a_root_low, aclk, aresetn, done_reg, 64'(root_reg) * 64'(root_reg) <= 64'(orig_reg))
    `ASSERT_IMP(a_root_high, aclk, aresetn, done_reg, (64'(root_reg) + 64'd1) * (64'(root_reg) + 64'd1) > 64'(orig_reg))
    `ASSERT_NEXT(a_start_busy, aclk, aresetn, start, busy_reg)

endmodule

FILE: rtl/golden_section_min_range_search.sv
// sequence: a load writes one table entry while idle; a query runs setup, then golden-section
// steps (loop check, new probe, table read, three squares, sum), then the final compare,
// table read, 31-step square root and result load
// items: one at a time; the next item is taken only once the result is loaded, and the
// search speed is set by the single shared multiplier and the one table read port
// reset: synchronous active-low aresetn clears control state; the table is not cleared
`include "assert_macros.svh"

module golden_section_min_range_search (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         cfg_wr_en,
    input  logic [gsmr_pkg::CNT_W-1:0]   cfg_wr_data,
    // input items
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic [15:0]                  s_entry_index,
    input  logic [gsmr_pkg::TIME_W-1:0]  s_entry_time,
    input  logic signed [gsmr_pkg::COORD_W-1:0] s_coord_x,
    input  logic signed [gsmr_pkg::COORD_W-1:0] s_coord_y,
    input  logic signed [gsmr_pkg::COORD_W-1:0] s_coord_z,
    // results
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [15:0]                  m_best_index,
    output logic [gsmr_pkg::TIME_W-1:0]  m_best_time,
    output logic [gsmr_pkg::ROOT_W-1:0]  m_min_range
);

    localparam int AW = gsmr_pkg::ADDR_W;
    localparam int IW = gsmr_pkg::IDX_W;
    localparam int CW = gsmr_pkg::COORD_W;
    localparam int DW = gsmr_pkg::DIST_W;
    localparam int TW = gsmr_pkg::TIME_W;

    gsmr_pkg::state_t state_reg, state_next;

    // configuration register
    logic [gsmr_pkg::CNT_W-1:0] count_reg;

    // query registers
    logic [CW-1:0]  tx_reg, tx_next, ty_reg, ty_next, tz_reg, tz_next;
    logic [AW-1:0]  last_reg, last_next;
    logic [IW-1:0]  low_reg, low_next, high_reg, high_next;
    logic [IW-1:0]  p1_reg, p1_next, p2_reg, p2_next;
    logic [IW-1:0]  mid_reg, mid_next;
    logic [IW-1:0]  far_reg, far_next, near_reg, near_next;
    logic [DW-1:0]  d1_reg, d1_next, d2_reg, d2_next, dwin_reg, dwin_next;
    logic           side_reg, side_next;    // probe two lies above the middle
    logic           which_reg, which_next;  // probe being measured is probe two
    logic           init_reg, init_next;    // measuring the two first probes
    logic [gsmr_pkg::STEP_W-1:0] steps_reg, steps_next;
    logic [AW-1:0]  addr_reg, addr_next;
    logic [TW-1:0]  time_reg, time_next;

    // shared multiplier
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_reg, acc_reg, acc_next;

    // result register
    logic           m_valid_reg, m_valid_next;
    logic [15:0]    out_index_reg, out_index_next;
    logic [TW-1:0]  out_time_reg, out_time_next;
    logic [gsmr_pkg::ROOT_W-1:0] out_range_reg, out_range_next;

    // table and root unit
    logic                       ram_we;
    logic [gsmr_pkg::ENTRY_W-1:0] ram_rd;
    logic [TW-1:0]              rd_time;
    logic signed [CW-1:0]       rd_x, rd_y, rd_z;
    logic                       sq_start, sq_done;
    logic [gsmr_pkg::ROOT_W-1:0] sq_root;

    logic            in_xfer, out_free;
    logic [31:0]     n_eff;
    logic signed [CW:0] dx, dy, dz;
    logic [IW-1:0]   q_val, mix_val;
    logic signed [IW+1:0] span;
    logic            go_on;

    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign {rd_time, rd_x, rd_y, rd_z} = ram_rd;

    // effective entry count: zero acts as one, clipped to the table
    always_comb begin
        n_eff = 32'(count_reg);
        if (count_reg == '0) begin
            n_eff = 32'd1;
        end else if (32'(count_reg) > 32'(gsmr_pkg::TABLE_DEPTH)) begin
            n_eff = 32'(gsmr_pkg::TABLE_DEPTH);
        end
    end

    assign dx = $signed({tx_reg[CW-1], tx_reg}) - $signed({rd_x[CW-1], rd_x});
    assign dy = $signed({ty_reg[CW-1], ty_reg}) - $signed({rd_y[CW-1], rd_y});
    assign dz = $signed({tz_reg[CW-1], tz_reg}) - $signed({rd_z[CW-1], rd_z});

    assign q_val   = prod_reg[gsmr_pkg::Q_FRAC +: IW];
    assign mix_val = IW'(64'(acc_reg + prod_reg) >> gsmr_pkg::Q_FRAC);
    assign span    = $signed({2'b00, high_reg}) - $signed({2'b00, low_reg});
    assign go_on   = (span > (IW+2)'(gsmr_pkg::SPAN_TOL)) && (p1_reg != p2_reg)
                     && (steps_reg < gsmr_pkg::STEP_W'(gsmr_pkg::STEP_LIMIT));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gsmr_pkg::ST_IDLE: begin
                if (in_xfer && s_op == gsmr_pkg::OP_QUERY) begin
                    state_next = gsmr_pkg::ST_MID_MUL;
                end
            end
            gsmr_pkg::ST_MID_MUL:  state_next = gsmr_pkg::ST_MID_SET;
            gsmr_pkg::ST_MID_SET:  state_next = gsmr_pkg::ST_PRB_MUL;
            gsmr_pkg::ST_PRB_MUL:  state_next = gsmr_pkg::ST_PRB_SET;
            gsmr_pkg::ST_PRB_SET:  state_next = gsmr_pkg::ST_D_ADDR;
            gsmr_pkg::ST_MIX_FAR:  state_next = gsmr_pkg::ST_MIX_NEAR;
            gsmr_pkg::ST_MIX_NEAR: state_next = gsmr_pkg::ST_MIX_SET;
            gsmr_pkg::ST_MIX_SET:  state_next = gsmr_pkg::ST_D_ADDR;
            gsmr_pkg::ST_D_ADDR:   state_next = gsmr_pkg::ST_D_X;
            gsmr_pkg::ST_D_X:      state_next = gsmr_pkg::ST_D_Y;
            gsmr_pkg::ST_D_Y:      state_next = gsmr_pkg::ST_D_Z;
            gsmr_pkg::ST_D_Z:      state_next = gsmr_pkg::ST_D_SUM;
            gsmr_pkg::ST_D_SUM: begin
                if (init_reg && !which_reg) begin
                    state_next = gsmr_pkg::ST_D_ADDR;
                end else begin
                    state_next = gsmr_pkg::ST_LOOP;
                end
            end
            gsmr_pkg::ST_LOOP: begin
                state_next = go_on ? gsmr_pkg::ST_MIX_FAR : gsmr_pkg::ST_F_ADDR;
            end
            gsmr_pkg::ST_F_ADDR:   state_next = gsmr_pkg::ST_F_READ;
            gsmr_pkg::ST_F_READ:   state_next = gsmr_pkg::ST_ROOT;
            gsmr_pkg::ST_ROOT: begin
                if (sq_done) begin
                    state_next = gsmr_pkg::ST_OUT;
                end
            end
            gsmr_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = gsmr_pkg::ST_IDLE;
                end
            end
            default: state_next = gsmr_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer: handshake, table write, multiplier operands, root start
    always_comb begin
        s_ready  = (state_reg == gsmr_pkg::ST_IDLE);
        ram_we   = 1'b0;
        sq_start = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            gsmr_pkg::ST_IDLE: begin
                ram_we = in_xfer && (s_op == gsmr_pkg::OP_LOAD)
                         && (32'(s_entry_index) < 32'(gsmr_pkg::TABLE_DEPTH));
            end
            gsmr_pkg::ST_MID_MUL: begin
                mul_a = $signed(32'(last_reg));
                mul_b = $signed(32'(gsmr_pkg::COMP_Q));
            end
            gsmr_pkg::ST_PRB_MUL: begin
                mul_a = side_reg ? $signed(32'(IW'(last_reg) - mid_reg))
                                 : $signed(32'(mid_reg));
                mul_b = $signed(32'(gsmr_pkg::COMP_Q));
            end
            gsmr_pkg::ST_MIX_FAR: begin
                mul_a = $signed(32'(far_reg));
                mul_b = $signed(32'(gsmr_pkg::GOLD_Q));
            end
            gsmr_pkg::ST_MIX_NEAR: begin
                mul_a = $signed(32'(near_reg));
                mul_b = $signed(32'(gsmr_pkg::COMP_Q));
            end
            gsmr_pkg::ST_D_X: begin
                mul_a = 32'(dx);
                mul_b = 32'(dx);
            end
            gsmr_pkg::ST_D_Y: begin
                mul_a = 32'(dy);
                mul_b = 32'(dy);
            end
            gsmr_pkg::ST_D_Z: begin
                mul_a = 32'(dz);
                mul_b = 32'(dz);
            end
            gsmr_pkg::ST_F_READ: sq_start = 1'b1;
            default: begin
            end
        endcase
    end

    // datapath next values
    always_comb begin
        tx_next = tx_reg; ty_next = ty_reg; tz_next = tz_reg;
        last_next  = last_reg;
        low_next   = low_reg;   high_next = high_reg;
        p1_next    = p1_reg;    p2_next   = p2_reg;
        mid_next   = mid_reg;
        far_next   = far_reg;   near_next = near_reg;
        d1_next    = d1_reg;    d2_next   = d2_reg;
        dwin_next  = dwin_reg;
        side_next  = side_reg;  which_next = which_reg; init_next = init_reg;
        steps_next = steps_reg;
        addr_next  = addr_reg;
        time_next  = time_reg;
        acc_next   = acc_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        out_index_next = out_index_reg;
        out_time_next  = out_time_reg;
        out_range_next = out_range_reg;
        case (state_reg)
            gsmr_pkg::ST_IDLE: begin
                if (in_xfer && s_op == gsmr_pkg::OP_QUERY) begin
                    tx_next    = s_coord_x;
                    ty_next    = s_coord_y;
                    tz_next    = s_coord_z;
                    last_next  = AW'(n_eff - 32'd1);
                    low_next   = '0;
                    high_next  = IW'(n_eff - 32'd1);
                    steps_next = '0;
                end
            end
            gsmr_pkg::ST_MID_SET: begin
                // longer part above the middle puts probe one at the middle
                mid_next  = q_val;
                side_next = (IW'(last_reg) - q_val) > q_val;
                if ((IW'(last_reg) - q_val) > q_val) begin
                    p1_next = q_val;
                end else begin
                    p2_next = q_val;
                end
            end
            gsmr_pkg::ST_PRB_SET: begin
                if (side_reg) begin
                    p2_next = mid_reg + q_val;
                end else begin
                    p1_next = mid_reg - q_val;
                end
                which_next = 1'b0;
                init_next  = 1'b1;
                addr_next  = gsmr_pkg::clamp_addr(side_reg ? p1_reg : mid_reg - q_val,
                                                  last_reg);
            end
            gsmr_pkg::ST_MIX_NEAR: acc_next = prod_reg;
            gsmr_pkg::ST_MIX_SET: begin
                if (which_reg) begin
                    p2_next = mix_val;
                end else begin
                    p1_next = mix_val;
                end
                addr_next = gsmr_pkg::clamp_addr(mix_val, last_reg);
            end
            gsmr_pkg::ST_D_Y: acc_next = prod_reg;
            gsmr_pkg::ST_D_Z: acc_next = acc_reg + prod_reg;
            gsmr_pkg::ST_D_SUM: begin
                if (which_reg) begin
                    d2_next = DW'(acc_reg + prod_reg);
                end else begin
                    d1_next = DW'(acc_reg + prod_reg);
                end
                if (init_reg && !which_reg) begin
                    which_next = 1'b1;
                    addr_next  = gsmr_pkg::clamp_addr(p2_reg, last_reg);
                end else begin
                    init_next = 1'b0;
                end
            end
            gsmr_pkg::ST_LOOP: begin
                if (go_on) begin
                    steps_next = steps_reg + 1'b1;
                    if (d2_reg < d1_reg) begin
                        // move the low bound up, new probe above
                        low_next   = p1_reg;
                        p1_next    = p2_reg;
                        d1_next    = d2_reg;
                        far_next   = high_reg;
                        near_next  = p2_reg;
                        which_next = 1'b1;
                    end else begin
                        // move the high bound down, new probe below
                        high_next  = p2_reg;
                        p2_next    = p1_reg;
                        d2_next    = d1_reg;
                        far_next   = low_reg;
                        near_next  = p1_reg;
                        which_next = 1'b0;
                    end
                end else begin
                    // probe two wins a tie
                    if (d1_reg < d2_reg) begin
                        addr_next = gsmr_pkg::clamp_addr(p1_reg, last_reg);
                        dwin_next = d1_reg;
                    end else begin
                        addr_next = gsmr_pkg::clamp_addr(p2_reg, last_reg);
                        dwin_next = d2_reg;
                    end
                end
            end
            gsmr_pkg::ST_F_READ: time_next = rd_time;
            gsmr_pkg::ST_OUT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_index_next = 16'(addr_reg);
                    out_time_next  = time_reg;
                    out_range_next = sq_root;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gsmr_pkg::ST_IDLE;
            count_reg   <= gsmr_pkg::CNT_W'(65536);
            m_valid_reg <= 1'b0;
            steps_reg   <= '0;
            init_reg    <= 1'b0;
            which_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            steps_reg   <= steps_next;
            init_reg    <= init_next;
            which_reg   <= which_next;
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
        end
        tx_reg <= tx_next; ty_reg <= ty_next; tz_reg <= tz_next;
        last_reg  <= last_next;
        low_reg   <= low_next;  high_reg <= high_next;
        p1_reg    <= p1_next;   p2_reg   <= p2_next;
        mid_reg   <= mid_next;
        far_reg   <= far_next;  near_reg <= near_next;
        d1_reg    <= d1_next;   d2_reg   <= d2_next;
        dwin_reg  <= dwin_next;
        side_reg  <= side_next;
        addr_reg  <= addr_next;
        time_reg  <= time_next;
        prod_reg  <= mul_a * mul_b;
        acc_reg   <= acc_next;
        out_index_reg <= out_index_next;
        out_time_reg  <= out_time_next;
        out_range_reg <= out_range_next;
    end

    // one memory holds time and position of each entry
    gsmr_ram #(
        .WIDTH(gsmr_pkg::ENTRY_W),
        .DEPTH(gsmr_pkg::TABLE_DEPTH)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(AW'(s_entry_index)),
        .wr_data({s_entry_time, s_coord_x, s_coord_y, s_coord_z}),
        .rd_addr(addr_reg),
        .rd_data(ram_rd)
    );

    gsmr_isqrt u_isqrt (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (sq_start),
        .value  (dwin_reg),
        .done   (sq_done),
        .root   (sq_root)
    );

    assign m_valid      = m_valid_reg;
    assign m_best_index = out_index_reg;
    assign m_best_time  = out_time_reg;
    assign m_min_range  = out_range_reg;

    `ASSERT_IMP(a_addr_range, aclk, aresetn, state_reg == gsmr_pkg::ST_D_ADDR, addr_reg <= last_reg)
    `ASSERT_IMP(a_step_bound, aclk, aresetn, 1'b1, steps_reg <= gsmr_pkg::STEP_W'(gsmr_pkg::STEP_LIMIT))
    `ASSERT_NEXT(a_out_load, aclk, aresetn, state_reg == gsmr_pkg::ST_OUT && out_free, m_valid_reg && state_reg == gsmr_pkg::ST_IDLE)

endmodule
